>>> sv/rsmt_pkg.sv
// Package for the random sample multiset table.
// Holds the transaction structs, mode and error codes, and the control state type.
package rsmt_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    localparam int RND_W = 32;
    localparam int VAL_W = 32;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [VAL_W-1:0] value;
        logic [RND_W-1:0]        random_word;
    } req_t;

    typedef struct packed {
        logic                    flag;
        logic signed [VAL_W-1:0] sample_value;
        logic [1:0]              error;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_MOVE,
        ST_FIN
    } state_t;

endpackage

>>> sv/random_sample_multiset_table.sv
// Random sample multiset table: DEPTH entries in a ring of cells rotated past one head port.
// Insert makes at most one rotation of the ring, remove up to two, sample a bit-serial modulo
// then one rotation; one transaction at a time.
// Reset clears the entry count and control; cell contents stay undefined until written.
// Depends on rsmt_pkg and rsmt_cell.
module random_sample_multiset_table #(
    parameter int DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rsmt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rsmt_pkg::rsp_t rsp
);
    import rsmt_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int BW = $clog2(RND_W);

    logic [VAL_W-1:0] q [DEPTH];
    logic             shift;
    logic             wr;
    logic [VAL_W-1:0] wdata;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    step_reg, step_next;
    logic [BW-1:0]    bit_reg, bit_next;
    logic [1:0]       op_reg, op_next;
    logic [VAL_W-1:0] key_reg, key_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [VAL_W-1:0] last_reg, last_next;
    logic             found_reg, found_next;
    rsp_t             pend_reg, pend_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [CW:0]      trial;
    logic             occ;
    logic             hit;
    logic             last_step;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_ring
            rsmt_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .wr    ((k == DEPTH - 1) ? wr : 1'b0),
                .d     ((k == DEPTH - 1) ? q[0] : q[(k + 1) % DEPTH]),
                .wdata (wdata),
                .q     (q[k])
            );
        end
    endgenerate

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        bit_next       = bit_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rnd_next       = rnd_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        found_next     = found_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        shift          = 1'b0;
        wr             = 1'b0;
        wdata          = key_reg;
        trial          = {rem_reg, rnd_reg[RND_W-1]};
        occ            = (CW'(step_reg) < count_reg);
        hit            = occ && (q[0] == key_reg);
        last_step      = (step_reg == IW'(DEPTH - 1));

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.mode;
                    key_next   = req.value;
                    rnd_next   = req.random_word;
                    step_next  = '0;
                    bit_next   = '0;
                    rem_next   = '0;
                    found_next = 1'b0;
                    pend_next  = '0;
                    case (req.mode)
                        MODE_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                pend_next.error = ERR_FULL;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            state_next = ST_SCAN;
                        end
                        MODE_SAMPLE:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.error = ERR_EMPTY;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, count_reg})
                begin
                    rem_next = CW'(trial - {1'b0, count_reg});
                end
                else
                begin
                    rem_next = CW'(trial);
                end
                rnd_next = {rnd_reg[RND_W-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BW'(RND_W - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                shift     = 1'b1;
                step_next = last_step ? '0 : step_reg + 1'b1;
                case (op_reg)
                    MODE_INSERT:
                    begin
                        if (hit)
                        begin
                            found_next = 1'b1;
                        end
                        if (CW'(step_reg) == count_reg)
                        begin
                            wr = 1'b1;
                        end
                        if (last_step)
                        begin
                            pend_next.flag = !found_next;
                            count_next     = count_reg + 1'b1;
                            state_next     = ST_FIN;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (hit && !found_reg)
                        begin
                            found_next = 1'b1;
                            idx_next   = step_reg;
                        end
                        if (CW'(step_reg) == count_reg - 1'b1)
                        begin
                            last_next = q[0];
                        end
                        if (last_step)
                        begin
                            state_next = found_next ? ST_MOVE : ST_FIN;
                        end
                    end
                    default:
                    begin
                        if (step_reg == rem_reg[IW-1:0])
                        begin
                            pend_next.sample_value = q[0];
                        end
                        if (last_step)
                        begin
                            state_next = ST_FIN;
                        end
                    end
                endcase
            end
            ST_MOVE:
            begin
                shift     = 1'b1;
                wdata     = last_reg;
                wr        = (step_reg == idx_reg);
                step_next = last_step ? '0 : step_reg + 1'b1;
                if (last_step)
                begin
                    pend_next.flag = 1'b1;
                    count_next     = count_reg - 1'b1;
                    state_next     = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            bit_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            bit_reg       <= bit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        rnd_reg   <= rnd_next;
        rem_reg   <= rem_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
        found_reg <= found_next;
        pend_reg  <= pend_next;
        rsp_reg   <= rsp_next;
    end
endmodule

>>> sv/rsmt_cell.sv
// One storage cell of the rotating entry ring.
// Takes its neighbor's entry on each shift; the tail cell can take a write instead. Uses rsmt_pkg.
module rsmt_cell (
    input  logic                           clk,
    input  logic                           shift,
    input  logic                           wr,
    input  logic [rsmt_pkg::VAL_W-1:0]     d,
    input  logic [rsmt_pkg::VAL_W-1:0]     wdata,
    output logic [rsmt_pkg::VAL_W-1:0]     q
);
    import rsmt_pkg::*;

    logic [VAL_W-1:0] q_reg;
    logic [VAL_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (shift)
        begin
            q_next = wr ? wdata : d;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;
endmodule
